// ===== rtl/core/mwc_pkg.sv =====
package mwc_pkg;

    // Block geometry.
    localparam int LAG      = 8;
    localparam int WORD_W   = 64;
    localparam int HALF_W   = WORD_W / 2;
    localparam int IDX_W    = $clog2(LAG);
    localparam int POS_W    = $clog2(LAG + 1);

    // Field widths of the stream beats.
    localparam int SEED_IDX_W = 3;
    localparam int S_DATA_W   = 72;
    localparam int CFG_IDX_W  = 1;

    // Reset value of the multiplier register.
    localparam logic [WORD_W-1:0] MUL_RESET = 64'd16996179571824182298;

    // Scrambler rotations.
    localparam int ROT_A = 17;
    localparam int ROT_B = 53;

    // Command codes carried in tuser.
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLE   = 1'd1;

    typedef logic [WORD_W-1:0] word_t;

    // Output scrambler: u ^ rotl(u, 17) ^ rotl(u, 53).
    function automatic word_t scramble(input word_t u);
        word_t ra;
        word_t rb;
        ra = (u << ROT_A) | (u >> (WORD_W - ROT_A));
        rb = (u << ROT_B) | (u >> (WORD_W - ROT_B));
        return u ^ ra ^ rb;
    endfunction

endpackage

// ===== rtl/core/mwc_word_ram.sv =====
module mwc_word_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       re,
    input  logic [mwc_pkg::IDX_W-1:0]  raddr,
    input  logic                       we,
    input  logic [mwc_pkg::IDX_W-1:0]  waddr,
    input  mwc_pkg::word_t             wdata,
    output mwc_pkg::word_t             rdata
);

    mwc_pkg::word_t            mem [mwc_pkg::LAG];
    mwc_pkg::word_t            rd_data_reg;
    logic                      rd_valid_reg;
    logic [mwc_pkg::LAG-1:0]   valid_reg;

    // Storage array, one write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Per-entry valid bits; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/mwc_mul_unit.sv =====
module mwc_mul_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mwc_pkg::word_t  a,
    input  mwc_pkg::word_t  x,
    input  mwc_pkg::word_t  c,
    output logic            done,
    output mwc_pkg::word_t  lo,
    output mwc_pkg::word_t  hi
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                         busy_reg;
    logic [2:0]                   step_reg;
    logic                         done_reg;
    logic [mwc_pkg::WORD_W-1:0]   pp_reg;
    logic [1:0]                   sh_reg;
    logic [2*mwc_pkg::WORD_W-1:0] acc_reg;

    logic [1:0]                   sel;
    logic [mwc_pkg::HALF_W-1:0]   a_half;
    logic [mwc_pkg::HALF_W-1:0]   x_half;
    logic [mwc_pkg::WORD_W-1:0]   prod;
    logic [2*mwc_pkg::WORD_W-1:0] pp_aligned;

    // Pick the half-word pair for this partial product.
    always_comb
    begin
        sel    = start ? 2'd0 : step_reg[1:0];
        a_half = sel[0] ? a[mwc_pkg::WORD_W-1:mwc_pkg::HALF_W] : a[mwc_pkg::HALF_W-1:0];
        x_half = sel[1] ? x[mwc_pkg::WORD_W-1:mwc_pkg::HALF_W] : x[mwc_pkg::HALF_W-1:0];
        prod   = a_half * x_half;
    end

    // Align the registered partial product to its weight.
    always_comb
    begin
        case (sh_reg)
            2'd1:    pp_aligned = {{mwc_pkg::HALF_W{1'b0}}, pp_reg, {mwc_pkg::HALF_W{1'b0}}};
            2'd2:    pp_aligned = {pp_reg, {mwc_pkg::WORD_W{1'b0}}};
            default: pp_aligned = {{mwc_pkg::WORD_W{1'b0}}, pp_reg};
        endcase
    end

    // Sequencing of the four partial products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd1;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // Multiply stage and accumulator; the accumulator starts at the carry.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {{mwc_pkg::WORD_W{1'b0}}, c};
            pp_reg  <= prod;
            sh_reg  <= 2'({1'b0, sel[0]} + {1'b0, sel[1]});
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_aligned;
            pp_reg  <= prod;
            sh_reg  <= 2'({1'b0, sel[0]} + {1'b0, sel[1]});
        end
    end

    assign done = done_reg;
    assign lo   = acc_reg[mwc_pkg::WORD_W-1:0];
    assign hi   = acc_reg[2*mwc_pkg::WORD_W-1:mwc_pkg::WORD_W];

    // A new product is never started while one is in flight.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiply started while busy");

endmodule

// ===== rtl/core/mwc_fullperiod_prng.sv =====
// Channel  Direction  Beat contents
// s_*      in         tuser: cmd; tdata: seed_index, seed_value
// m_*      out        tdata: random_value
// cfg_*    in         index 0 multiplier, index 1 scramble_enable
//
// A draw from a live block reads its word, and ready returns once the output register takes it.
// A draw that finds the block used up first regenerates it: a multiply pass, the H step, a
// subtract pass and, on a borrow, an add pass; the shared 32x32 multiplier forms four partial
// products a word. Reset clears the state words to zero, carry to one, and marks the block
// used up. A stalled result waits in the output register while loads are still taken; the
// next draw waits for that register to drain.
module mwc_fullperiod_prng (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mwc_pkg::S_DATA_W-1:0]  s_tdata,   // seed_index[2:0], seed_value[66:3]
    input  logic [0:0]                    s_tuser,   // cmd[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mwc_pkg::WORD_W-1:0]    m_tdata,   // random_value[63:0]
    input  logic                          cfg_we,
    input  logic [mwc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mwc_pkg::WORD_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_M_GO   = 3'd1;
    localparam logic [2:0] S_M_WAIT = 3'd2;
    localparam logic [2:0] S_H      = 3'd3;
    localparam logic [2:0] S_SUB    = 3'd4;
    localparam logic [2:0] S_ADD    = 3'd5;
    localparam logic [2:0] S_D_OUT  = 3'd6;

    localparam logic [mwc_pkg::IDX_W-1:0] LAST_IDX = mwc_pkg::IDX_W'(mwc_pkg::LAG - 1);
    localparam logic [mwc_pkg::POS_W-1:0] POS_END  = mwc_pkg::POS_W'(mwc_pkg::LAG);

    logic [2:0]                  state_reg,    state_next;
    logic [mwc_pkg::POS_W-1:0]   pos_reg,      pos_next;
    logic [mwc_pkg::IDX_W-1:0]   idx_reg,      idx_next;
    logic                        top_reg,      top_next;
    mwc_pkg::word_t              carry_reg,    carry_next;
    logic                        brw_reg,      brw_next;
    logic [1:0]                  cy_reg,       cy_next;
    mwc_pkg::word_t              mult_reg,     mult_next;
    logic                        scr_reg,      scr_next;
    logic                        out_valid_reg, out_valid_next;
    mwc_pkg::word_t              out_data_reg;

    logic                        ram_re;
    logic [mwc_pkg::IDX_W-1:0]   ram_raddr;
    logic                        ram_we;
    logic [mwc_pkg::IDX_W-1:0]   ram_waddr;
    mwc_pkg::word_t              ram_wdata;
    mwc_pkg::word_t              ram_rdata;

    logic                        mul_start;
    logic                        mul_done;
    mwc_pkg::word_t              mul_lo;
    mwc_pkg::word_t              mul_hi;

    logic                        in_acc;
    logic                        out_load;
    logic                        seed_ok;
    logic [mwc_pkg::SEED_IDX_W-1:0] seed_index;
    mwc_pkg::word_t              seed_value;
    mwc_pkg::word_t              h_sum;
    mwc_pkg::word_t              subtr;
    logic [mwc_pkg::WORD_W:0]    diff;
    logic [mwc_pkg::WORD_W:0]    sum;

    assign seed_index = s_tdata[mwc_pkg::SEED_IDX_W-1:0];
    assign seed_value = s_tdata[mwc_pkg::SEED_IDX_W+mwc_pkg::WORD_W-1:mwc_pkg::SEED_IDX_W];
    assign seed_ok    = 32'(seed_index) < mwc_pkg::LAG;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_D_OUT) && (!out_valid_reg || m_tready);

    // Block word store.
    mwc_word_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (ram_re),
        .raddr (ram_raddr),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared multiply-add unit: a*x + c.
    mwc_mul_unit u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mult_reg),
        .x     (ram_rdata),
        .c     (carry_reg),
        .done  (mul_done),
        .lo    (mul_lo),
        .hi    (mul_hi)
    );

    // Reduction arithmetic on the word just read.
    always_comb
    begin
        h_sum = (top_reg ? mult_reg : '0) + carry_reg;
        if (idx_reg == '0)
        begin
            subtr = {carry_reg[mwc_pkg::WORD_W-2:0], 1'b0};
        end
        else if (idx_reg == mwc_pkg::IDX_W'(1))
        begin
            subtr = mwc_pkg::WORD_W'({1'b0, carry_reg[mwc_pkg::WORD_W-1]} + {1'b0, brw_reg});
        end
        else
        begin
            subtr = mwc_pkg::WORD_W'(brw_reg);
        end
        diff = {1'b0, ram_rdata} - {1'b0, subtr};
        sum  = {1'b0, ram_rdata} + (mwc_pkg::WORD_W + 1)'(cy_reg);
    end

    // Configuration registers.
    always_comb
    begin
        mult_next = mult_reg;
        scr_next  = scr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mwc_pkg::CFG_MULTIPLIER: mult_next = cfg_data;
                mwc_pkg::CFG_SCRAMBLE:   scr_next  = cfg_data[0];
                default:                 mult_next = mult_reg;
            endcase
        end
    end

    // Sequencer: draws, seed loads and the three regeneration passes.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        carry_next = carry_reg;
        brw_next   = brw_reg;
        cy_next    = cy_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = mul_lo;
        mul_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser[0] == mwc_pkg::CMD_LOAD)
                    begin
                        ram_we     = seed_ok;
                        ram_waddr  = mwc_pkg::IDX_W'(seed_index);
                        ram_wdata  = seed_value;
                        top_next   = 1'b0;
                        carry_next = mwc_pkg::WORD_W'(1);
                        pos_next   = POS_END;
                    end
                    else if (pos_reg >= POS_END)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = S_M_GO;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = pos_reg[mwc_pkg::IDX_W-1:0];
                        state_next = S_D_OUT;
                    end
                end
            end

            S_M_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_M_WAIT;
            end

            S_M_WAIT:
            begin
                if (mul_done)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = mul_lo;
                    carry_next = mul_hi;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_H;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg + mwc_pkg::IDX_W'(1);
                        idx_next   = idx_reg + mwc_pkg::IDX_W'(1);
                        state_next = S_M_GO;
                    end
                end
            end

            S_H:
            begin
                carry_next = h_sum;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                brw_next   = 1'b0;
                state_next = S_SUB;
            end

            S_SUB:
            begin
                ram_we    = 1'b1;
                ram_wdata = diff[mwc_pkg::WORD_W-1:0];
                brw_next  = diff[mwc_pkg::WORD_W];
                ram_re    = 1'b1;
                if (idx_reg != LAST_IDX)
                begin
                    ram_raddr = idx_reg + mwc_pkg::IDX_W'(1);
                    idx_next  = idx_reg + mwc_pkg::IDX_W'(1);
                end
                else if (diff[mwc_pkg::WORD_W])
                begin
                    // Borrow out of the top: decrement H and add two back.
                    carry_next = carry_reg - mwc_pkg::WORD_W'(1);
                    ram_raddr  = '0;
                    idx_next   = '0;
                    cy_next    = 2'd2;
                    state_next = S_ADD;
                end
                else
                begin
                    top_next   = 1'b0;
                    pos_next   = '0;
                    ram_raddr  = '0;
                    state_next = S_D_OUT;
                end
            end

            S_ADD:
            begin
                ram_we    = 1'b1;
                ram_wdata = sum[mwc_pkg::WORD_W-1:0];
                cy_next   = {1'b0, sum[mwc_pkg::WORD_W]};
                ram_re    = 1'b1;
                if (idx_reg != LAST_IDX)
                begin
                    ram_raddr = idx_reg + mwc_pkg::IDX_W'(1);
                    idx_next  = idx_reg + mwc_pkg::IDX_W'(1);
                end
                else
                begin
                    top_next   = sum[mwc_pkg::WORD_W];
                    pos_next   = '0;
                    ram_raddr  = '0;
                    state_next = S_D_OUT;
                end
            end

            S_D_OUT:
            begin
                if (out_load)
                begin
                    pos_next   = pos_reg + mwc_pkg::POS_W'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= POS_END;
            idx_reg       <= '0;
            top_reg       <= 1'b0;
            carry_reg     <= mwc_pkg::WORD_W'(1);
            brw_reg       <= 1'b0;
            cy_reg        <= '0;
            mult_reg      <= mwc_pkg::MUL_RESET;
            scr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            carry_reg     <= carry_next;
            brw_reg       <= brw_next;
            cy_reg        <= cy_next;
            mult_reg      <= mult_next;
            scr_reg       <= scr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output data, scrambled on request.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= scr_reg ? mwc_pkg::scramble(ram_rdata) : ram_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A word is never read in the same cycle it is rewritten.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same word");

    // Every draw leaves a read position inside the block.
    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_OUT) |-> (pos_reg < POS_END))
        else $error("draw with the block used up");

    // A seed load restarts the generator.
    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser[0] == mwc_pkg::CMD_LOAD))
        |=> ((pos_reg == POS_END) && (carry_reg == mwc_pkg::WORD_W'(1)) && !top_reg))
        else $error("seed load did not restart the block");

endmodule

// ===== tb/sv/mwc_checker.sv =====
`timescale 1ns / 100ps

// Watches the seed/draw input stream, the random word output stream and the
// register writes. It keeps its own copy of the generator state, works out
// the word each draw must return and compares every output beat against it.
module mwc_checker
    import mwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // seed_index[2:0], seed_value[66:3]
    input  logic [0:0]           s_tuser,   // cmd[0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [WORD_W-1:0]    m_tdata,   // random_value[63:0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   errors,
    output int                   outstanding
);

    // Shadow copy of the registers and of the generator state.
    word_t mul_reg;
    logic  scramble_on;
    word_t lag_words [LAG];
    logic  top_bit;
    word_t carry_reg;
    int    read_pos;

    // Words that draws have asked for and the output has not yet delivered.
    word_t pending_words [$];

    // Rotate-xor output whitening.
    function automatic word_t whiten(input word_t u);
        word_t rot_a;
        word_t rot_b;
        rot_a = {u[WORD_W-1-ROT_A:0], u[WORD_W-1:WORD_W-ROT_A]};
        rot_b = {u[WORD_W-1-ROT_B:0], u[WORD_W-1:WORD_W-ROT_B]};
        return u ^ rot_a ^ rot_b;
    endfunction

    // Builds the next block: chained multiply-add, then reduction modulo
    // base^LAG + 2 by subtracting twice the high part.
    task automatic refill_block();
        logic [2*WORD_W-1:0] prod;
        logic [WORD_W:0]     diff;
        word_t               c;
        word_t               h;
        word_t               cv;
        logic                b;
        c = carry_reg;
        for (int i = 0; i < LAG; i++)
        begin
            prod = {{WORD_W{1'b0}}, mul_reg} * {{WORD_W{1'b0}}, lag_words[i]}
                 + {{WORD_W{1'b0}}, c};
            lag_words[i] = prod[WORD_W-1:0];
            c = prod[2*WORD_W-1:WORD_W];
        end
        h = (top_bit ? mul_reg : '0) + c;

        // Subtract 2*H across the block with borrow.
        diff = {1'b0, lag_words[0]} - {1'b0, h << 1};
        lag_words[0] = diff[WORD_W-1:0];
        b = diff[WORD_W];
        diff = {1'b0, lag_words[1]} - {1'b0, (h >> (WORD_W-1)) + word_t'(b)};
        lag_words[1] = diff[WORD_W-1:0];
        b = diff[WORD_W];
        for (int i = 2; i < LAG; i++)
        begin
            diff = {1'b0, lag_words[i]} - {{WORD_W{1'b0}}, b};
            lag_words[i] = diff[WORD_W-1:0];
            b = diff[WORD_W];
        end

        // A borrow out of the top gives back one from H and adds 2 to the block.
        if (!b)
        begin
            top_bit = 1'b0;
        end
        else
        begin
            h = h - 1;
            cv = 2;
            for (int i = 0; i < LAG; i++)
            begin
                diff = {1'b0, lag_words[i]} + {1'b0, cv};
                lag_words[i] = diff[WORD_W-1:0];
                cv = word_t'(diff[WORD_W]);
            end
            top_bit = cv[0];
        end
        carry_reg = h;
        read_pos = 0;
    endtask

    always @(posedge clk)
    begin
        word_t want;
        if (!rst_n)
        begin
            mul_reg     = MUL_RESET;
            scramble_on = 1'b0;
            for (int i = 0; i < LAG; i++)
            begin
                lag_words[i] = '0;
            end
            top_bit   = 1'b0;
            carry_reg = 1;
            read_pos  = LAG;
            pending_words.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                if (cfg_index == CFG_MULTIPLIER)
                begin
                    mul_reg = cfg_data;
                end
                else if (cfg_index == CFG_SCRAMBLE)
                begin
                    scramble_on = cfg_data[0];
                end
            end

            // Output beat: compare with the oldest pending word.
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: random_value expected none got %h", $time, m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: random_value expected %h got %h",
                                 $time, want, m_tdata);
                        errors <= errors + 1;
                    end
                end
            end

            // Input beat: a seed load restarts the block, a draw yields one word.
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_LOAD)
                begin
                    if (int'(s_tdata[SEED_IDX_W-1:0]) < LAG)
                    begin
                        lag_words[s_tdata[SEED_IDX_W-1:0]] =
                            s_tdata[SEED_IDX_W+WORD_W-1:SEED_IDX_W];
                    end
                    top_bit   = 1'b0;
                    carry_reg = 1;
                    read_pos  = LAG;
                end
                else
                begin
                    if (read_pos >= LAG)
                    begin
                        refill_block();
                    end
                    want = lag_words[read_pos];
                    read_pos = read_pos + 1;
                    if (scramble_on)
                    begin
                        want = whiten(want);
                    end
                    pending_words.push_back(want);
                end
            end
            outstanding <= pending_words.size();
        end
    end

endmodule

// ===== tb/sv/tb_mwc_fullperiod_prng.sv =====
`timescale 1ns / 100ps

module tb_mwc_fullperiod_prng;
    import mwc_pkg::*;

    localparam int    CYCLE_LIMIT   = 1000000;
    localparam int    SETTLE_CYCLES = 8 * LAG + 16;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    PHASE_ITEMS   = 190;
    localparam word_t TOP_BIT_ONLY  = 64'h8000_0000_0000_0000;
    localparam word_t ALL_ONES      = '1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;   // seed_index[2:0], seed_value[66:3]
    logic [0:0]           s_tuser   = '0;   // cmd[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [WORD_W-1:0]    m_tdata;          // random_value[63:0]
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    int errors;
    int outstanding;
    int cycle_count;

    // Set by the stimulus: the final stretch runs without idling, and one
    // long output hold-off is requested early in the random part.
    bit quiet        = 1'b0;
    bit hold_off_req = 1'b0;

    mwc_fullperiod_prng u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mwc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Seed words lean toward the extremes now and then.
    function automatic word_t pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return ALL_ONES;
            2: return word_t'($urandom_range(0, 3));
            3: return TOP_BIT_ONLY;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one input beat, after an occasional idle burst, and returns at
    // the edge where it is taken.
    task automatic send_beat(input logic cmd, input logic [SEED_IDX_W-1:0] idx,
                             input word_t value);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W-SEED_IDX_W-WORD_W){1'b0}}, value, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Draw beats carry random seed fields, which the block must ignore.
    task automatic draw_words(input int count);
        repeat (count) send_beat(CMD_DRAW, SEED_IDX_W'($urandom), {$urandom, $urandom});
    endtask

    // Stops offering, waits for every pending word and for a possible refill.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input word_t mul_value, input logic scr_value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MULTIPLIER;
        cfg_data  <= mul_value;
        @(posedge clk);
        cfg_index <= CFG_SCRAMBLE;
        cfg_data  <= {{(WORD_W-1){1'b0}}, scr_value};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly draw runs, single loads that break the block, and full reseeds
    // followed by enough draws to pass through a refill.
    task automatic random_phase(input int n_items);
        int sent;
        int r;
        int run;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                run = $urandom_range(1, 20);
                draw_words(run);
                sent += run;
            end
            else if (r < 85)
            begin
                send_beat(CMD_LOAD, SEED_IDX_W'($urandom), pick_word());
                sent += 1;
            end
            else
            begin
                for (int i = 0; i < LAG; i++)
                begin
                    send_beat(CMD_LOAD, SEED_IDX_W'(i), pick_word());
                end
                run = $urandom_range(LAG, 3 * LAG);
                draw_words(run);
                sent += LAG + run;
            end
        end
    endtask

    // Output side: random stall bursts, one long hold-off, none at the end.
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 16);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        word_t mul_list [6];
        bit    scr_list [6];
        mul_list = '{MUL_RESET, '0, ALL_ONES, 64'd1, {$urandom, $urandom},
                     {$urandom, $urandom}};
        scr_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: refill from zeros and two in word 7, one block edge.
        send_beat(CMD_LOAD, 3'd7, 64'd2);
        send_beat(CMD_DRAW, 3'd0, '0);
        send_beat(CMD_DRAW, 3'd7, ALL_ONES);
        draw_words(LAG - 1);
        settle();

        // Multiplier 2^63 on a block that is zero but for two in the top
        // word: the reduction borrows out, the top bit becomes one and the
        // next refill folds the multiplier back in.
        write_config(TOP_BIT_ONLY, 1'b1);
        for (int i = 0; i < LAG - 1; i++)
        begin
            send_beat(CMD_LOAD, SEED_IDX_W'(i), '0);
        end
        send_beat(CMD_LOAD, 3'd7, 64'd2);
        draw_words(LAG + 1);
        settle();

        // Random phases over a spread of register settings.
        for (int p = 0; p < 6; p++)
        begin
            write_config(mul_list[p], scr_list[p]);
            if (p == 0)
            begin
                hold_off_req = 1'b1;
            end
            if (p == 5)
            begin
                quiet = 1'b1;
            end
            random_phase(PHASE_ITEMS);
            settle();
        end

        if (errors == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mwc_pkg.sv
rtl/core/mwc_word_ram.sv
rtl/core/mwc_mul_unit.sv
rtl/core/mwc_fullperiod_prng.sv
tb/sv/mwc_checker.sv
tb/sv/tb_mwc_fullperiod_prng.sv
